FILE: hdl/hta_pkg.sv
// Shared types and constants for the handle table allocator.
`default_nettype none
package hta_pkg;

  localparam int unsigned CAPACITY_DEF = 256;

  localparam int unsigned OP_W      = 2;
  localparam int unsigned HANDLE_W  = 9;
  localparam int unsigned TYPE_W    = 4;
  localparam int unsigned PAYLOAD_W = 32;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned COUNT_W   = 9;

  localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_CLOSE  = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_DEAD  = 2'd3;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } hta_state_t;

  typedef struct packed {
    logic                 valid;
    logic [TYPE_W-1:0]    obj_type;
    logic [PAYLOAD_W-1:0] payload;
  } hta_slot_t;

  typedef struct packed {
    logic init;
    logic rd_en;
    logic pop;
    logic push;
  } hta_stk_cmd_t;

endpackage
`default_nettype wire

FILE: hdl/hta_free_stack.sv
// Free slot stack: one memory of slot indices and its top pointer.
`default_nettype none
module hta_free_stack #(
  parameter int unsigned CAPACITY = hta_pkg::CAPACITY_DEF,
  localparam int unsigned IDXW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int unsigned CNTW = $clog2(CAPACITY + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire hta_pkg::hta_stk_cmd_t cmd,
  input  wire logic [IDXW-1:0]      init_idx,
  input  wire logic [IDXW-1:0]      push_slot,
  output logic                      empty,
  output logic [IDXW-1:0]           pop_slot
);

  logic [IDXW-1:0] stack_mem [CAPACITY];
  logic [CNTW-1:0] top_r;
  logic [CNTW-1:0] top_nxt;
  logic [IDXW-1:0] rd_data_r;
  logic            not_full;

  assign empty    = (top_r == '0);
  assign not_full = (top_r < CNTW'(CAPACITY));
  assign pop_slot = rd_data_r;

  always_comb begin
    top_nxt = top_r;
    if (cmd.pop && !empty) begin
      top_nxt = top_r - CNTW'(1);
    end else if (cmd.push && not_full) begin
      top_nxt = top_r + CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r <= CNTW'(CAPACITY);
    end else begin
      top_r <= top_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      stack_mem[init_idx] <= IDXW'(CAPACITY - 1) - init_idx;
    end else if (cmd.push && not_full) begin
      stack_mem[IDXW'(top_r)] <= push_slot;
    end
    if (cmd.rd_en) begin
      rd_data_r <= stack_mem[IDXW'(top_r - CNTW'(1))];
    end
  end

endmodule
`default_nettype wire

FILE: hdl/handle_table_allocator.sv
// Top level of the handle table allocator with a stacked free list.
//
// The input channel carries one command transaction: allocate, look up or
// close, with a one-based handle and the type and payload to store. The
// output channel returns one result transaction per command: status,
// allocated handle, stored type and payload, and the live handle count.
// A command passes through two states: in S_IDLE the cycle of acceptance
// reads the slot memory and the free stack memory, and in S_EXEC the
// block checks, writes back and loads the output register. The next
// command is accepted only once the block is back in S_IDLE.
// After reset the block sweeps both memories, one entry per cycle, over all
// CAPACITY entries; in_stall stays high during that sweep.
// The result sits in an output register. While the receiver stalls, a
// command already read waits in S_EXEC and in_stall stays high.
// The first allocation after reset returns handle 1; handle 0 is invalid.
`default_nettype none
module handle_table_allocator #(
  parameter int unsigned CAPACITY = hta_pkg::CAPACITY_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [hta_pkg::OP_W-1:0]        in_operation,
  input  wire logic [hta_pkg::HANDLE_W-1:0]    in_handle,
  input  wire logic [hta_pkg::TYPE_W-1:0]      in_obj_type,
  input  wire logic [hta_pkg::PAYLOAD_W-1:0]   in_payload,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [hta_pkg::STATUS_W-1:0]         out_status,
  output logic [hta_pkg::HANDLE_W-1:0]         out_result_handle,
  output logic [hta_pkg::TYPE_W-1:0]           out_result_type,
  output logic [hta_pkg::PAYLOAD_W-1:0]        out_result_payload,
  output logic [hta_pkg::COUNT_W-1:0]          out_live_count
);

  localparam int unsigned IDXW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNTW = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CNTW > hta_pkg::HANDLE_W) ? CNTW : hta_pkg::HANDLE_W;

  hta_pkg::hta_state_t   state_r, state_nxt;
  logic [IDXW-1:0]       clr_cnt_r, clr_cnt_nxt;
  logic [CNTW-1:0]       live_r, live_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic [hta_pkg::OP_W-1:0]      op_r;
  logic [IDXW-1:0]               slot_idx_r;
  logic                          range_err_r;
  logic [hta_pkg::TYPE_W-1:0]    type_r;
  logic [hta_pkg::PAYLOAD_W-1:0] payload_r;

  logic [hta_pkg::STATUS_W-1:0]  status_r, status_nxt;
  logic [hta_pkg::HANDLE_W-1:0]  rhandle_r, rhandle_nxt;
  logic [hta_pkg::TYPE_W-1:0]    rtype_r, rtype_nxt;
  logic [hta_pkg::PAYLOAD_W-1:0] rpayload_r, rpayload_nxt;

  hta_pkg::hta_slot_t slot_mem [CAPACITY];
  hta_pkg::hta_slot_t slot_rd_r;
  hta_pkg::hta_slot_t slot_wdata;
  logic [IDXW-1:0]    slot_waddr;
  logic               slot_we;
  logic               slot_re;

  hta_pkg::hta_stk_cmd_t stk_cmd;
  logic                  stk_empty;
  logic [IDXW-1:0]       stk_slot;

  logic            accept;
  logic            commit;
  logic            in_range_err;
  logic [IDXW-1:0] in_slot_idx;

  assign in_stall  = (state_r != hta_pkg::S_IDLE);
  assign accept    = (state_r == hta_pkg::S_IDLE) && in_valid;
  assign commit    = (state_r == hta_pkg::S_EXEC) && (!out_valid_r || !out_stall);

  assign in_range_err = (in_handle == '0) || (CMPW'(in_handle) > CMPW'(CAPACITY));
  assign in_slot_idx  = IDXW'(CMPW'(in_handle) - CMPW'(1));

  hta_free_stack #(
    .CAPACITY (CAPACITY)
  ) u_free_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (stk_cmd),
    .init_idx  (clr_cnt_r),
    .push_slot (slot_idx_r),
    .empty     (stk_empty),
    .pop_slot  (stk_slot)
  );

  always_comb begin
    state_nxt    = state_r;
    clr_cnt_nxt  = clr_cnt_r;
    live_nxt     = live_r;
    slot_we      = 1'b0;
    slot_waddr   = slot_idx_r;
    slot_wdata   = '0;
    slot_re      = 1'b0;
    stk_cmd      = '0;
    status_nxt   = hta_pkg::STAT_OK;
    rhandle_nxt  = '0;
    rtype_nxt    = '0;
    rpayload_nxt = '0;
    case (state_r)
      hta_pkg::S_CLEAR: begin
        slot_we      = 1'b1;
        slot_waddr   = clr_cnt_r;
        stk_cmd.init = 1'b1;
        clr_cnt_nxt  = clr_cnt_r + IDXW'(1);
        if (clr_cnt_r == IDXW'(CAPACITY - 1)) begin
          state_nxt = hta_pkg::S_IDLE;
        end
      end
      hta_pkg::S_IDLE: begin
        if (accept) begin
          slot_re       = 1'b1;
          stk_cmd.rd_en = 1'b1;
          state_nxt     = hta_pkg::S_EXEC;
        end
      end
      hta_pkg::S_EXEC: begin
        if (commit) begin
          state_nxt = hta_pkg::S_IDLE;
          case (op_r)
            hta_pkg::OP_ALLOC: begin
              if (stk_empty) begin
                status_nxt = hta_pkg::STAT_FULL;
              end else begin
                slot_we     = 1'b1;
                slot_waddr  = stk_slot;
                slot_wdata  = '{valid: 1'b1, obj_type: type_r, payload: payload_r};
                stk_cmd.pop = 1'b1;
                live_nxt    = live_r + CNTW'(1);
                rhandle_nxt = hta_pkg::HANDLE_W'(CNTW'(stk_slot) + CNTW'(1));
              end
            end
            hta_pkg::OP_LOOKUP: begin
              if (range_err_r) begin
                status_nxt = hta_pkg::STAT_RANGE;
              end else if (!slot_rd_r.valid) begin
                status_nxt = hta_pkg::STAT_DEAD;
              end else begin
                rtype_nxt    = slot_rd_r.obj_type;
                rpayload_nxt = slot_rd_r.payload;
              end
            end
            hta_pkg::OP_CLOSE: begin
              if (range_err_r) begin
                status_nxt = hta_pkg::STAT_RANGE;
              end else if (!slot_rd_r.valid) begin
                status_nxt = hta_pkg::STAT_DEAD;
              end else begin
                slot_we      = 1'b1;
                stk_cmd.push = 1'b1;
                if (live_r != '0) begin
                  live_nxt = live_r - CNTW'(1);
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_nxt = hta_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hta_pkg::S_CLEAR;
      clr_cnt_r   <= '0;
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      live_r      <= live_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r        <= in_operation;
      slot_idx_r  <= in_slot_idx;
      range_err_r <= in_range_err;
      type_r      <= in_obj_type;
      payload_r   <= in_payload;
    end
    if (commit) begin
      status_r   <= status_nxt;
      rhandle_r  <= rhandle_nxt;
      rtype_r    <= rtype_nxt;
      rpayload_r <= rpayload_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    if (slot_re) begin
      slot_rd_r <= slot_mem[in_slot_idx];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_result_handle  = rhandle_r;
  assign out_result_type    = rtype_r;
  assign out_result_payload = rpayload_r;
  assign out_live_count     = hta_pkg::COUNT_W'(live_r);

endmodule
`default_nettype wire
